/* design/bdc_pkg.sv */
// Shared types and constants for the baud divisor calculator.
package bdc_pkg;

    localparam int BAUD_W    = 16;
    localparam int CLOCK_W   = 27;
    localparam int WORD_W    = 16;
    localparam int SCALED_W  = 32;
    localparam int QUOT_W    = 30;
    localparam int WHOLE_W   = 23;
    localparam int MANT_W    = 12;
    localparam int FRAC_W    = 4;
    localparam int REM_W     = 7;
    localparam int PROD_W    = 62;
    localparam int FPROD_W   = 22;
    localparam int FSCALE_W  = 11;

    localparam logic [CLOCK_W-1:0] CLOCK_RESET = 27'd72000000;
    localparam logic [4:0]         CLOCK_SCALE = 5'd25;

    localparam logic [31:0]        RECIP_100   = 32'h51EB851F;
    localparam int                 RECIP_SHIFT = 37;
    localparam logic [6:0]         HUNDRED     = 7'd100;

    localparam logic [FSCALE_W-1:0] FRAC_ROUND  = 11'd50;
    localparam logic [FSCALE_W-1:0] FRAC_RECIP  = 11'd1311;
    localparam int                  FRAC_SHIFT  = 17;

    typedef struct packed {
        logic valid;
        logic zero;
    } bdc_tag_t;

    // Rounded four-bit fraction of a remainder below one hundred; the carry is dropped.
    function automatic logic [FRAC_W-1:0] round_fraction(input logic [REM_W-1:0] rem);
        logic [FSCALE_W-1:0] scaled;
        logic [FPROD_W-1:0]  prod;
        scaled = {rem, {FRAC_W{1'b0}}} + FRAC_ROUND;
        prod   = FPROD_W'(scaled) * FPROD_W'(FRAC_RECIP);
        return prod[FRAC_SHIFT +: FRAC_W];
    endfunction

endpackage

/* design/bdc_if.sv */
// Handshake interfaces for the request and result channels.
interface bdc_baud_if;
    import bdc_pkg::*;

    logic              valid;
    logic              ready;
    logic [BAUD_W-1:0] baud_rate;

    modport source (output valid, output baud_rate, input ready);
    modport sink   (input valid, input baud_rate, output ready);
endinterface

interface bdc_word_if;
    import bdc_pkg::*;

    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] divisor_word;

    modport source (output valid, output divisor_word, input ready);
    modport sink   (input valid, input divisor_word, output ready);
endinterface

/* design/bdc_divider.sv */
// Pipelined restoring divider, one quotient bit per stage.
module bdc_divider (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        advance,
    input  bdc_pkg::bdc_tag_t           in_tag,
    input  logic [bdc_pkg::QUOT_W-1:0]  dividend,
    input  logic [bdc_pkg::BAUD_W-1:0]  divisor,
    output bdc_pkg::bdc_tag_t           out_tag,
    output logic [bdc_pkg::QUOT_W-1:0]  quotient
);
    import bdc_pkg::*;

    bdc_tag_t          tag_reg      [0:QUOT_W];
    bdc_tag_t          tag_next     [0:QUOT_W];
    logic [QUOT_W-1:0] work_reg     [0:QUOT_W];
    logic [QUOT_W-1:0] work_next    [0:QUOT_W];
    logic [BAUD_W-1:0] rem_reg      [0:QUOT_W];
    logic [BAUD_W-1:0] rem_next     [0:QUOT_W];
    logic [BAUD_W-1:0] divisor_reg  [0:QUOT_W];
    logic [BAUD_W-1:0] divisor_next [0:QUOT_W];

    always_comb
    begin
        logic [BAUD_W:0] trial;
        logic [BAUD_W:0] diff;
        logic            ge;
        tag_next[0]     = in_tag;
        work_next[0]    = dividend;
        rem_next[0]     = '0;
        divisor_next[0] = divisor;
        for (int k = 1; k <= QUOT_W; k++)
        begin
            trial = {rem_reg[k-1], work_reg[k-1][QUOT_W-1]};
            diff  = trial - {1'b0, divisor_reg[k-1]};
            ge    = (trial >= {1'b0, divisor_reg[k-1]});
            tag_next[k]     = tag_reg[k-1];
            divisor_next[k] = divisor_reg[k-1];
            rem_next[k]     = ge ? diff[BAUD_W-1:0] : trial[BAUD_W-1:0];
            work_next[k]    = {work_reg[k-1][QUOT_W-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= QUOT_W; k++)
            begin
                tag_reg[k] <= '0;
            end
        end
        else if (advance)
        begin
            for (int k = 0; k <= QUOT_W; k++)
            begin
                tag_reg[k] <= tag_next[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int k = 0; k <= QUOT_W; k++)
            begin
                work_reg[k]    <= work_next[k];
                rem_reg[k]     <= rem_next[k];
                divisor_reg[k] <= divisor_next[k];
            end
        end
    end

    assign out_tag  = tag_reg[QUOT_W];
    assign quotient = work_reg[QUOT_W];

endmodule

/* design/bdc_split.sv */
// Splits the scaled divider into mantissa and rounded fraction over three stages.
module bdc_split (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        advance,
    input  bdc_pkg::bdc_tag_t           in_tag,
    input  logic [bdc_pkg::QUOT_W-1:0]  quotient,
    output logic                        out_valid,
    output logic [bdc_pkg::WORD_W-1:0]  divisor_word
);
    import bdc_pkg::*;

    bdc_tag_t           tag_a_reg;
    bdc_tag_t           tag_b_reg;
    logic               valid_c_reg;
    logic [QUOT_W-1:0]  quot_a_reg;
    logic [WHOLE_W-1:0] whole_a_reg;
    logic [WHOLE_W-1:0] whole_a_next;
    logic [REM_W-1:0]   rem_b_reg;
    logic [REM_W-1:0]   rem_b_next;
    logic [MANT_W-1:0]  mant_b_reg;
    logic [WORD_W-1:0]  word_c_reg;
    logic [WORD_W-1:0]  word_c_next;
    logic [PROD_W-1:0]  recip_prod;
    logic [QUOT_W-1:0]  back_prod;
    logic [QUOT_W-1:0]  rem_full;

    assign recip_prod   = PROD_W'(quotient) * PROD_W'(RECIP_100);
    assign whole_a_next = recip_prod[RECIP_SHIFT +: WHOLE_W];

    assign back_prod  = QUOT_W'(whole_a_reg) * QUOT_W'(HUNDRED);
    assign rem_full   = quot_a_reg - back_prod;
    assign rem_b_next = rem_full[REM_W-1:0];

    assign word_c_next = tag_b_reg.zero ? '0 : {mant_b_reg, round_fraction(rem_b_reg)};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_a_reg   <= '0;
            tag_b_reg   <= '0;
            valid_c_reg <= 1'b0;
        end
        else if (advance)
        begin
            tag_a_reg   <= in_tag;
            tag_b_reg   <= tag_a_reg;
            valid_c_reg <= tag_b_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            quot_a_reg  <= quotient;
            whole_a_reg <= whole_a_next;
            rem_b_reg   <= rem_b_next;
            mant_b_reg  <= whole_a_reg[MANT_W-1:0];
            word_c_reg  <= word_c_next;
        end
    end

    assign out_valid    = valid_c_reg;
    assign divisor_word = word_c_reg;

endmodule

/* design/baud_divisor_calculator.sv */
// Top level of the baud divisor calculator: config register, divider and word assembly.
//
//   channel   dir  payload                  handshake
//   requests  in   baud_rate[15:0]          valid/ready
//   results   out  divisor_word[15:0]       valid/ready
//   cfg       in   cfg_data[26:0] clock_hz  cfg_we, no wait
//
// One word enters per cycle while the output is not stalled and passes through one entry
// stage, thirty divider stages (one quotient bit each) and three stages that split off the
// mantissa and round the fraction. Reset clears every valid bit and sets the clock to
// 72 MHz. A stalled result word holds the whole pipeline, so ready falls only while
// the output register is full and not being taken.
module baud_divisor_calculator (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [bdc_pkg::CLOCK_W-1:0]  cfg_data,
    bdc_baud_if.sink                     requests,
    bdc_word_if.source                   results
);
    import bdc_pkg::*;

    logic [CLOCK_W-1:0]  clock_hz_reg;
    logic [SCALED_W-1:0] scaled_clock;
    logic                advance;
    bdc_tag_t            entry_tag;
    bdc_tag_t            div_tag;
    logic [QUOT_W-1:0]   div_quotient;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_hz_reg <= CLOCK_RESET;
        end
        else if (cfg_we)
        begin
            clock_hz_reg <= cfg_data;
        end
    end

    assign advance        = !results.valid || results.ready;
    assign requests.ready = advance;

    assign scaled_clock    = SCALED_W'(clock_hz_reg) * SCALED_W'(CLOCK_SCALE);
    assign entry_tag.valid = requests.valid;
    assign entry_tag.zero  = (requests.baud_rate == '0);

    bdc_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .in_tag   (entry_tag),
        .dividend (scaled_clock[SCALED_W-1:2]),
        .divisor  (requests.baud_rate),
        .out_tag  (div_tag),
        .quotient (div_quotient)
    );

    bdc_split u_split (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .in_tag       (div_tag),
        .quotient     (div_quotient),
        .out_valid    (results.valid),
        .divisor_word (results.divisor_word)
    );

endmodule

/* tb/sv/tb_top.sv */
// Self-checking testbench for the baud divisor calculator with a built-in divisor predictor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bdc_pkg::*;

    localparam int PIPE_DEPTH = 34;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CLOCK_W-1:0] cfg_data;

    bdc_baud_if req_if ();
    bdc_word_if res_if ();

    baud_divisor_calculator uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .requests (req_if),
        .results  (res_if)
    );

    logic [CLOCK_W-1:0] clock_hz_now;
    logic [WORD_W-1:0]  expected_words[$];
    logic [WORD_W-1:0]  oldest_word;
    int                 mismatches;
    int                 sender_idle_pct;
    int                 receiver_idle_pct;

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        req_if.valid = 1'b0;
        req_if.baud_rate = '0;
        res_if.ready = 1'b0;
        clock_hz_now = CLOCK_RESET;
        mismatches = 0;
        sender_idle_pct = 12;
        receiver_idle_pct = 71;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #(5_000_000);
        $display("tb_top NOT OK");
        $finish;
    end

    function automatic logic [WORD_W-1:0] calc_divisor(input logic [BAUD_W-1:0] baud);
        logic [63:0] scaled;
        logic [63:0] whole;
        logic [63:0] rem;
        logic [63:0] frac;
        logic [63:0] word;
        if (baud == '0)
            return '0;
        scaled = (64'd25 * 64'(clock_hz_now)) / (64'd4 * 64'(baud));
        whole  = scaled / 64'd100;
        rem    = scaled - 64'd100 * whole;
        frac   = ((rem * 64'd16 + 64'd50) / 64'd100) & 64'h0F;
        word   = (whole << 4) | frac;
        return word[WORD_W-1:0];
    endfunction

    task automatic report_mismatch(input string what, input logic [WORD_W-1:0] want,
                                   input logic [WORD_W-1:0] got);
        $display("%0t: %s: expected %h, got %h", $realtime, what, want, got);
        mismatches++;
    endtask

    always @(negedge clk)
        res_if.ready <= (receiver_idle_pct == 0) || ($urandom_range(99) >= receiver_idle_pct);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_if.valid && req_if.ready)
                expected_words.push_back(calc_divisor(req_if.baud_rate));
            if (res_if.valid && res_if.ready)
            begin
                if (expected_words.size() == 0)
                    report_mismatch("unexpected divisor word", '0, res_if.divisor_word);
                else
                begin
                    oldest_word = expected_words.pop_front();
                    if (res_if.divisor_word !== oldest_word)
                        report_mismatch("divisor_word", oldest_word, res_if.divisor_word);
                end
            end
        end
    end

    task automatic send_baud(input logic [BAUD_W-1:0] baud);
        while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct)
        begin
            req_if.valid <= 1'b0;
            @(negedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.baud_rate <= baud;
        do
            @(posedge clk);
        while (!req_if.ready);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        req_if.valid <= 1'b0;
        do
            @(negedge clk);
        while (expected_words.size() != 0);
    endtask

    task automatic write_clock(input logic [CLOCK_W-1:0] hz);
        wait_drained();
        cfg_we <= 1'b1;
        cfg_data <= hz;
        @(negedge clk);
        cfg_we <= 1'b0;
        clock_hz_now = hz;
    endtask

    function automatic logic [BAUD_W-1:0] pick_baud();
        int common_rates[8] = '{300, 1200, 2400, 4800, 9600, 19200, 38400, 57600};
        if ($urandom_range(99) == 0)
            return '0;
        case ($urandom_range(9))
            0: return BAUD_W'($urandom_range(255, 1));
            1: return BAUD_W'(common_rates[$urandom_range(7)]);
            2: return BAUD_W'(65535 - $urandom_range(255));
            default: return BAUD_W'($urandom_range(65535, 1));
        endcase
    endfunction

    function automatic logic [CLOCK_W-1:0] pick_clock();
        case ($urandom_range(5))
            0: return CLOCK_W'(100000000);
            1: return CLOCK_W'($urandom_range(1000, 1));
            2: return CLOCK_RESET;
            3: return {CLOCK_W{1'b1}};
            default: return CLOCK_W'($urandom_range(100000000, 1));
        endcase
    endfunction

    task automatic test_reset_clock();
        send_baud(16'd1);
        send_baud(16'hFFFF);
        send_baud(16'd0);
        send_baud(16'd9600);
        send_baud(16'd57600);
        send_baud(16'h5555);
        send_baud(16'hAAAA);
        send_baud(16'h8000);
    endtask

    task automatic test_zero_clock();
        write_clock('0);
        send_baud(16'd1);
        send_baud(16'hFFFF);
        send_baud(16'd4800);
    endtask

    task automatic test_clock_extremes();
        write_clock(CLOCK_W'(1));
        send_baud(16'd1);
        send_baud(16'd2);
        send_baud(16'hFFFF);
        write_clock({CLOCK_W{1'b1}});
        send_baud(16'd1);
        send_baud(16'hFFFF);
        // At 100 MHz a rate of 97 leaves a remainder whose fraction rounds up to sixteen.
        write_clock(CLOCK_W'(100000000));
        send_baud(16'd97);
        send_baud(16'd1);
        send_baud(16'd33);
    endtask

    task automatic test_random(input int src_idle, input int sink_idle);
        sender_idle_pct = src_idle;
        receiver_idle_pct = sink_idle;
        repeat (4)
        begin
            write_clock(pick_clock());
            repeat (130)
            begin
                if ($urandom_range(199) == 0)
                    wait_drained();
                send_baud(pick_baud());
            end
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_clock();
        test_zero_clock();
        test_clock_extremes();
        test_random(12, 71);
        test_random(71, 12);
        test_random(0, 0);

        wait_drained();
        repeat (PIPE_DEPTH + 10) @(negedge clk);
        if (mismatches == 0 && expected_words.size() == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

/* baud_divisor_calculator.f */
design/bdc_pkg.sv
design/bdc_if.sv
design/bdc_divider.sv
design/bdc_split.sv
design/baud_divisor_calculator.sv
tb/sv/tb_top.sv
